// ----- hw/rtl/scl_pkg.sv -----
`timescale 1ns / 1ps
// Package for the semicolon command line parser: line state, result types,
// character and keyword constants, and the per-byte update and decode functions.
package scl_pkg;

  // Field count bound and the width of the field index
  localparam int MAX_FIELDS = 10;
  localparam int IDX_W      = $clog2(MAX_FIELDS + 1);

  // Characters
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // Keywords as they sit right-aligned in the 48-bit word shifter
  localparam logic [47:0] KW_H      = 48'h48;
  localparam logic [47:0] KW_C      = 48'h43;
  localparam logic [47:0] KW_SET    = 48'h534554;
  localparam logic [47:0] KW_GET    = 48'h474554;
  localparam logic [47:0] KW_PING   = 48'h50494E47;
  localparam logic [47:0] KW_RST    = 48'h525354;
  localparam logic [47:0] KW_UPD    = 48'h555044;
  localparam logic [47:0] KW_TOG    = 48'h544F47;
  localparam logic [47:0] KW_ACK    = 48'h41434B;
  localparam logic [47:0] KW_ERR    = 48'h455252;
  localparam logic [47:0] KW_STATUS = 48'h535441545553;
  localparam logic [47:0] KW_PONG   = 48'h504F4E47;

  typedef enum logic [1:0] {
    SND_NONE = 2'd0,
    SND_H    = 2'd1,
    SND_C    = 2'd2
  } sender_t;

  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_SET    = 4'd1,
    CMD_GET    = 4'd2,
    CMD_PING   = 4'd3,
    CMD_RST    = 4'd4,
    CMD_UPD    = 4'd5,
    CMD_TOG    = 4'd6,
    CMD_ACK    = 4'd7,
    CMD_ERR    = 4'd8,
    CMD_STATUS = 4'd9,
    CMD_PONG   = 4'd10
  } cmd_t;

  typedef enum logic [3:0] {
    MSG_ERROR   = 4'd0,
    MSG_HSET    = 4'd1,
    MSG_HGET    = 4'd2,
    MSG_HPING   = 4'd3,
    MSG_HRST    = 4'd4,
    MSG_HUPD    = 4'd5,
    MSG_HTOG    = 4'd6,
    MSG_CACK    = 4'd7,
    MSG_CERR    = 4'd8,
    MSG_CSTATUS = 4'd9,
    MSG_CPONG   = 4'd10,
    MSG_CRST    = 4'd11
  } msg_t;

  // Keyword flag bits of the third field
  localparam int KWF_STATUS = 0;
  localparam int KWF_SET    = 1;

  typedef struct packed {
    logic [IDX_W-1:0]  field_index;
    logic [2:0]        field_length;
    logic [47:0]       word_shift;
    sender_t           sender;
    cmd_t              command;
    logic [1:0]        kw_flags;
    logic [15:0]       hex_acc;
    logic              hex_valid;
    logic [15:0]       dec_acc;
    logic              dec_neg;
    logic              dec_stop;
    logic [1:0][15:0]  masks;
    logic [1:0]        mask_ok;
    logic [4:0][15:0]  values;
  } line_st_t;

  typedef struct packed {
    msg_t              msg_type;
    logic [15:0]       mask;
    logic [15:0]       mask_b;
    logic [15:0]       error_code;
    logic [3:0][15:0]  adc;
    logic [15:0]       temperature;
  } result_t;

  // Per-field state back to its empty value
  function automatic line_st_t clear_field(line_st_t s);
    line_st_t r;
    r              = s;
    r.field_length = 3'd0;
    r.word_shift   = '0;
    r.hex_acc      = '0;
    r.hex_valid    = 1'b1;
    r.dec_acc      = '0;
    r.dec_neg      = 1'b0;
    r.dec_stop     = 1'b0;
    return r;
  endfunction

  // Whole line state back to its reset value
  function automatic line_st_t clear_line();
    line_st_t r;
    r           = '0;
    r.sender    = SND_NONE;
    r.command   = CMD_NONE;
    r.hex_valid = 1'b1;
    return r;
  endfunction

  function automatic logic word_is(line_st_t s, logic [2:0] len, logic [47:0] kw);
    return (s.field_length == len) && (s.word_shift == kw);
  endfunction

  function automatic cmd_t match_command(line_st_t s);
    cmd_t c;
    c = CMD_NONE;
    if      (word_is(s, 3'd3, KW_SET))    c = CMD_SET;
    else if (word_is(s, 3'd3, KW_GET))    c = CMD_GET;
    else if (word_is(s, 3'd4, KW_PING))   c = CMD_PING;
    else if (word_is(s, 3'd3, KW_RST))    c = CMD_RST;
    else if (word_is(s, 3'd3, KW_UPD))    c = CMD_UPD;
    else if (word_is(s, 3'd3, KW_TOG))    c = CMD_TOG;
    else if (word_is(s, 3'd3, KW_ACK))    c = CMD_ACK;
    else if (word_is(s, 3'd3, KW_ERR))    c = CMD_ERR;
    else if (word_is(s, 3'd6, KW_STATUS)) c = CMD_STATUS;
    else if (word_is(s, 3'd4, KW_PONG))   c = CMD_PONG;
    return c;
  endfunction

  // Add one ordinary character to the open field
  function automatic line_st_t feed_char(line_st_t s, logic [7:0] c);
    line_st_t   r;
    logic       is_dig;
    logic       is_lo;
    logic       is_up;
    logic [3:0] nib;
    logic [15:0] dec10;
    r      = s;
    is_dig = (c >= CH_0) && (c <= CH_9);
    is_lo  = (c >= CH_LA) && (c <= CH_LF);
    is_up  = (c >= CH_UA) && (c <= CH_UF);
    nib    = is_dig ? 4'(c - CH_0) :
             is_lo  ? 4'(c - CH_LA + 8'd10) : 4'(c - CH_UA + 8'd10);
    dec10  = {s.dec_acc[12:0], 3'b000} + {s.dec_acc[14:0], 1'b0} + {12'd0, nib};

    r.word_shift = {s.word_shift[39:0], c};
    if (s.field_length != 3'd7) r.field_length = s.field_length + 3'd1;

    // Hex: exactly four digits
    if (!(is_dig || is_lo || is_up) || (s.field_length >= 3'd4)) begin
      r.hex_valid = 1'b0;
    end else begin
      r.hex_acc = {s.hex_acc[11:0], nib};
    end

    // Decimal: optional sign, digits until the first non-digit
    if (!s.dec_stop) begin
      if ((s.field_length == 3'd0) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
        if (c == CH_MINUS) r.dec_neg = 1'b1;
      end else if (is_dig) begin
        r.dec_acc = dec10;
      end else begin
        r.dec_stop = 1'b1;
      end
    end
    return r;
  endfunction

  // Capture what the closing field means at its position, then empty it
  function automatic line_st_t close_field(line_st_t s);
    line_st_t    r;
    logic        hok;
    logic [15:0] dec;
    logic [2:0]  vi;
    r   = s;
    hok = s.hex_valid && (s.field_length == 3'd4);
    dec = s.dec_neg ? 16'(16'd0 - s.dec_acc) : s.dec_acc;
    vi  = 3'(s.field_index - IDX_W'(3));
    if (s.field_index == IDX_W'(0)) begin
      if      (word_is(s, 3'd1, KW_H)) r.sender = SND_H;
      else if (word_is(s, 3'd1, KW_C)) r.sender = SND_C;
      else                             r.sender = SND_NONE;
    end else if (s.field_index == IDX_W'(1)) begin
      r.command = match_command(s);
    end else if (s.field_index == IDX_W'(2)) begin
      r.kw_flags[KWF_STATUS] = word_is(s, 3'd6, KW_STATUS);
      r.kw_flags[KWF_SET]    = word_is(s, 3'd3, KW_SET);
      r.masks[0] = s.hex_acc;
      if (hok) r.mask_ok[0] = 1'b1;
    end else if (s.field_index <= IDX_W'(7)) begin
      if (s.field_index == IDX_W'(3)) begin
        r.masks[1] = s.hex_acc;
        if (hok) r.mask_ok[1] = 1'b1;
      end
      r.values[vi] = dec;
    end
    return clear_field(r);
  endfunction

  // Check sender, command and field count; gather the fields that apply
  function automatic result_t decode(line_st_t s);
    result_t          r;
    logic [IDX_W-1:0] cnt;
    logic             h0;
    r          = '0;
    r.msg_type = MSG_ERROR;
    cnt = (s.field_index == IDX_W'(MAX_FIELDS)) ? IDX_W'(MAX_FIELDS)
                                                : s.field_index + IDX_W'(1);
    h0  = s.mask_ok[0];
    if ((cnt >= IDX_W'(2)) && (s.sender == SND_H)) begin
      unique case (s.command)
        CMD_SET: if ((cnt == IDX_W'(3)) && h0) begin
          r.msg_type = MSG_HSET;
          r.mask     = s.masks[0];
        end
        CMD_GET: if ((cnt == IDX_W'(3)) && s.kw_flags[KWF_STATUS]) begin
          r.msg_type = MSG_HGET;
        end
        CMD_PING: r.msg_type = MSG_HPING;
        CMD_RST: if (cnt == IDX_W'(2)) begin
          r.msg_type = MSG_HRST;
        end
        CMD_UPD: if ((cnt == IDX_W'(4)) && (s.mask_ok == 2'b11)) begin
          r.msg_type = MSG_HUPD;
          r.mask     = s.masks[0];
          r.mask_b   = s.masks[1];
        end
        CMD_TOG: if ((cnt == IDX_W'(3)) && h0) begin
          r.msg_type = MSG_HTOG;
          r.mask     = s.masks[0];
        end
        default: r.msg_type = MSG_ERROR;
      endcase
    end else if ((cnt >= IDX_W'(2)) && (s.sender == SND_C)) begin
      unique case (s.command)
        CMD_ACK: if ((cnt == IDX_W'(4)) && s.kw_flags[KWF_SET] && s.mask_ok[1]) begin
          r.msg_type = MSG_CACK;
          r.mask     = s.masks[1];
        end
        CMD_ERR: if ((cnt == IDX_W'(4)) && s.kw_flags[KWF_SET]) begin
          r.msg_type   = MSG_CERR;
          r.error_code = s.values[0];
        end
        CMD_STATUS: if ((cnt == IDX_W'(8)) && h0) begin
          r.msg_type    = MSG_CSTATUS;
          r.mask        = s.masks[0];
          r.adc[0]      = s.values[0];
          r.adc[1]      = s.values[1];
          r.adc[2]      = s.values[2];
          r.adc[3]      = s.values[3];
          r.temperature = s.values[4];
        end
        CMD_PONG: r.msg_type = MSG_CPONG;
        CMD_RST: if (cnt == IDX_W'(2)) begin
          r.msg_type = MSG_CRST;
        end
        default: r.msg_type = MSG_ERROR;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/semicolon_command_line_parser.sv -----
`timescale 1ns / 1ps
// Top level of the semicolon command line parser: input word register,
// per-byte line state update and the result register. Uses scl_pkg.
//
// Feed one character per word, with line_end set on the last character of
// the line. The block takes one word every cycle; a word is held in the
// input register, then updates the line state, and the last character of
// a line loads the result register at that same edge. The input side keeps
// running while a result waits and stalls only when a line end meets a
// result that has not been taken yet.
// The result gives the message type (zero on any parse error) with the masks
// and values that belong to it, all other fields zero.
module semicolon_command_line_parser
  import scl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_line_byte,
  input  logic               in_line_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_msg_type,
  output logic [15:0]        out_mask,
  output logic [15:0]        out_mask_b,
  output logic signed [15:0] out_error_code,
  output logic [15:0]        out_adc_0,
  output logic [15:0]        out_adc_1,
  output logic [15:0]        out_adc_2,
  output logic [15:0]        out_adc_3,
  output logic signed [15:0] out_temperature
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  line_st_t   line_r;
  line_st_t   line_nxt;
  line_st_t   st_char;
  line_st_t   st_final;
  result_t    res_r;
  result_t    res_nxt;
  logic       out_v_r;
  logic       proc_go;

  // Consume the held word unless it ends a line and the result slot is full
  assign proc_go  = in_v_r && (!in_end_r || !out_v_r || out_ready);
  assign in_ready = !in_v_r || proc_go;

  // Apply the held character, then close the last field at line end
  always_comb begin
    st_char = line_r;
    if (in_byte_r == CH_SEMI) begin
      if (line_r.field_index < IDX_W'(MAX_FIELDS)) begin
        st_char             = close_field(line_r);
        st_char.field_index = line_r.field_index + IDX_W'(1);
      end
    end else if (line_r.field_index < IDX_W'(MAX_FIELDS)) begin
      st_char = feed_char(line_r, in_byte_r);
    end

    st_final = st_char;
    if (st_char.field_index < IDX_W'(MAX_FIELDS)) begin
      st_final = close_field(st_char);
    end

    res_nxt  = decode(st_final);
    line_nxt = in_end_r ? clear_line() : st_char;
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_line_byte;
      in_end_r  <= in_line_end;
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= clear_line();
    end else if (proc_go) begin
      line_r <= line_nxt;
    end
  end

  // Result register: load on line end, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc_go && in_end_r) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && in_end_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_msg_type    = res_r.msg_type;
  assign out_mask        = res_r.mask;
  assign out_mask_b      = res_r.mask_b;
  assign out_error_code  = $signed(res_r.error_code);
  assign out_adc_0       = res_r.adc[0];
  assign out_adc_1       = res_r.adc[1];
  assign out_adc_2       = res_r.adc[2];
  assign out_adc_3       = res_r.adc[3];
  assign out_temperature = $signed(res_r.temperature);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for semicolon_command_line_parser: directed and random text
// lines go in, and each reply is compared with a line decoder kept here. Uses scl_pkg.
module testbench;
  import scl_pkg::*;

  // Expected reply of one line
  typedef struct packed {
    msg_t             kind;
    logic [15:0]      mask;
    logic [15:0]      mask_b;
    logic [15:0]      err_code;
    logic [3:0][15:0] adc;
    logic [15:0]      temp;
  } reply_t;

  typedef enum logic [1:0] {
    MUT_REPLACE,
    MUT_SPLIT,
    MUT_DROP,
    MUT_CASE
  } mutation_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_line_byte;
  logic               in_line_end;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_msg_type;
  logic [15:0]        out_mask;
  logic [15:0]        out_mask_b;
  logic signed [15:0] out_error_code;
  logic [15:0]        out_adc_0;
  logic [15:0]        out_adc_1;
  logic [15:0]        out_adc_2;
  logic [15:0]        out_adc_3;
  logic signed [15:0] out_temperature;

  reply_t     awaited_replies[$];
  logic [7:0] line_buf[$];
  int         errors;
  int         sent_bytes;
  logic       calm;
  string      hex_digits = "0123456789abcdefABCDEF";

  // Line decoder state
  int unsigned seg_count;
  logic [2:0]  seg_len;
  logic [47:0] seg_word;
  sender_t     who;
  cmd_t        verb;
  logic        status_kw;
  logic        set_kw;
  logic [15:0] hex_val;
  logic        hex_good;
  logic [15:0] num_val;
  logic        num_neg;
  logic        num_done;
  logic [15:0] mask_cap [2];
  logic [1:0]  mask_good;
  logic [15:0] val_cap [5];

  semicolon_command_line_parser u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_line_byte    (in_line_byte),
    .in_line_end     (in_line_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_msg_type    (out_msg_type),
    .out_mask        (out_mask),
    .out_mask_b      (out_mask_b),
    .out_error_code  (out_error_code),
    .out_adc_0       (out_adc_0),
    .out_adc_1       (out_adc_1),
    .out_adc_2       (out_adc_2),
    .out_adc_3       (out_adc_3),
    .out_temperature (out_temperature)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------- decoder

  function automatic void reset_segment();
    seg_len  = 3'd0;
    seg_word = '0;
    hex_val  = '0;
    hex_good = 1'b1;
    num_val  = '0;
    num_neg  = 1'b0;
    num_done = 1'b0;
  endfunction

  function automatic void reset_line_model();
    reset_segment();
    seg_count = 0;
    who       = SND_NONE;
    verb      = CMD_NONE;
    status_kw = 1'b0;
    set_kw    = 1'b0;
    mask_good = 2'b00;
    foreach (mask_cap[i]) mask_cap[i] = '0;
    foreach (val_cap[i]) val_cap[i] = '0;
  endfunction

  function automatic logic seg_is(int n, logic [47:0] kw);
    return (seg_len == 3'(n)) && (seg_word == kw);
  endfunction

  // Fold one ordinary character into the open field
  function automatic void absorb_char(logic [7:0] c);
    logic       digit;
    logic       hexd;
    logic [3:0] nib;
    digit = (c >= CH_0) && (c <= CH_9);
    hexd  = 1'b1;
    nib   = '0;
    if (digit) nib = 4'(c - CH_0);
    else if ((c >= CH_LA) && (c <= CH_LF)) nib = 4'(c - CH_LA + 8'd10);
    else if ((c >= CH_UA) && (c <= CH_UF)) nib = 4'(c - CH_UA + 8'd10);
    else hexd = 1'b0;

    if (!hexd || (seg_len >= 3'd4)) hex_good = 1'b0;
    else hex_val = {hex_val[11:0], nib};

    if (!num_done) begin
      if ((seg_len == 3'd0) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
        if (c == CH_MINUS) num_neg = 1'b1;
      end else if (digit) begin
        num_val = 16'(num_val * 16'd10 + 16'(c - CH_0));
      end else begin
        num_done = 1'b1;
      end
    end

    seg_word = {seg_word[39:0], c};
    if (seg_len != 3'd7) seg_len = seg_len + 3'd1;
  endfunction

  // Record what the closing field means at its position
  function automatic void close_segment();
    logic        hok;
    logic [15:0] dec;
    hok = hex_good && (seg_len == 3'd4);
    dec = num_neg ? 16'(16'd0 - num_val) : num_val;
    if (seg_count == 0) begin
      if (seg_is(1, KW_H)) who = SND_H;
      else if (seg_is(1, KW_C)) who = SND_C;
      else who = SND_NONE;
    end else if (seg_count == 1) begin
      if (seg_is(3, KW_SET)) verb = CMD_SET;
      else if (seg_is(3, KW_GET)) verb = CMD_GET;
      else if (seg_is(4, KW_PING)) verb = CMD_PING;
      else if (seg_is(3, KW_RST)) verb = CMD_RST;
      else if (seg_is(3, KW_UPD)) verb = CMD_UPD;
      else if (seg_is(3, KW_TOG)) verb = CMD_TOG;
      else if (seg_is(3, KW_ACK)) verb = CMD_ACK;
      else if (seg_is(3, KW_ERR)) verb = CMD_ERR;
      else if (seg_is(6, KW_STATUS)) verb = CMD_STATUS;
      else if (seg_is(4, KW_PONG)) verb = CMD_PONG;
      else verb = CMD_NONE;
    end else if (seg_count == 2) begin
      status_kw   = seg_is(6, KW_STATUS);
      set_kw      = seg_is(3, KW_SET);
      mask_cap[0] = hex_val;
      if (hok) mask_good[0] = 1'b1;
    end else if (seg_count <= 7) begin
      if (seg_count == 3) begin
        mask_cap[1] = hex_val;
        if (hok) mask_good[1] = 1'b1;
      end
      val_cap[seg_count - 3] = dec;
    end
    reset_segment();
  endfunction

  // Check sender, command and field count of a finished line
  function automatic reply_t decode_line();
    reply_t      r;
    int unsigned n;
    r      = '0;
    r.kind = MSG_ERROR;
    n      = (seg_count + 1 > MAX_FIELDS) ? MAX_FIELDS : seg_count + 1;
    if ((n >= 2) && (who == SND_H)) begin
      case (verb)
        CMD_SET: if ((n == 3) && mask_good[0]) begin
          r.kind = MSG_HSET;
          r.mask = mask_cap[0];
        end
        CMD_GET: if ((n == 3) && status_kw) r.kind = MSG_HGET;
        CMD_PING: r.kind = MSG_HPING;
        CMD_RST: if (n == 2) r.kind = MSG_HRST;
        CMD_UPD: if ((n == 4) && (mask_good == 2'b11)) begin
          r.kind   = MSG_HUPD;
          r.mask   = mask_cap[0];
          r.mask_b = mask_cap[1];
        end
        CMD_TOG: if ((n == 3) && mask_good[0]) begin
          r.kind = MSG_HTOG;
          r.mask = mask_cap[0];
        end
        default: r.kind = MSG_ERROR;
      endcase
    end else if ((n >= 2) && (who == SND_C)) begin
      case (verb)
        CMD_ACK: if ((n == 4) && set_kw && mask_good[1]) begin
          r.kind = MSG_CACK;
          r.mask = mask_cap[1];
        end
        CMD_ERR: if ((n == 4) && set_kw) begin
          r.kind     = MSG_CERR;
          r.err_code = val_cap[0];
        end
        CMD_STATUS: if ((n == 8) && mask_good[0]) begin
          r.kind = MSG_CSTATUS;
          r.mask = mask_cap[0];
          for (int i = 0; i < 4; i++) r.adc[i] = val_cap[i];
          r.temp = val_cap[4];
        end
        CMD_PONG: r.kind = MSG_CPONG;
        CMD_RST: if (n == 2) r.kind = MSG_CRST;
        default: r.kind = MSG_ERROR;
      endcase
    end
    return r;
  endfunction

  function automatic void predict_char(logic [7:0] c, logic last);
    if (c == CH_SEMI) begin
      if (seg_count < MAX_FIELDS) begin
        close_segment();
        seg_count++;
      end
    end else if (seg_count < MAX_FIELDS) begin
      absorb_char(c);
    end
    if (last) begin
      if (seg_count < MAX_FIELDS) close_segment();
      awaited_replies.push_back(decode_line());
      reset_line_model();
    end
  endfunction

  // Predict on every accepted word
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_char(in_line_byte, in_line_end);
  end

  // ---------------------------------------------------------------- checker

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t ns: reply with no line pending, type %0d", $time, out_msg_type);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("msg_type", 16'(want.kind), 16'(out_msg_type));
        check_field("mask", want.mask, out_mask);
        check_field("mask_b", want.mask_b, out_mask_b);
        check_field("error_code", want.err_code, out_error_code);
        check_field("adc_0", want.adc[0], out_adc_0);
        check_field("adc_1", want.adc[1], out_adc_1);
        check_field("adc_2", want.adc[2], out_adc_2);
        check_field("adc_3", want.adc[3], out_adc_3);
        check_field("temperature", want.temp, out_temperature);
      end
    end
  end

  // Stall the reply side now and then
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 10);
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && ($urandom_range(99) < 10)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_line_byte <= b;
    in_line_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  // Drop valid and hold until every pending reply is back
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    line_buf.delete();
    put_text(s);
    send_line();
  endtask

  function automatic void put_hex4();
    line_buf.push_back(CH_SEMI);
    repeat (4) line_buf.push_back(hex_digits[$urandom_range(21)]);
  endfunction

  // Optional sign, zero to six digits, sometimes trailing junk
  function automatic void put_decimal();
    int sign;
    line_buf.push_back(CH_SEMI);
    sign = $urandom_range(2);
    if (sign == 1) line_buf.push_back(CH_PLUS);
    else if (sign == 2) line_buf.push_back(CH_MINUS);
    repeat ($urandom_range(6)) line_buf.push_back(8'(CH_0 + $urandom_range(9)));
    if ($urandom_range(4) == 0) line_buf.push_back(8'($urandom_range(126, 33)));
  endfunction

  function automatic void put_extra_fields();
    repeat ($urandom_range(10)) begin
      line_buf.push_back(CH_SEMI);
      repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(126, 33)));
    end
  endfunction

  // One line of a known message with random content
  function automatic void build_wellformed();
    msg_t pick;
    line_buf.delete();
    pick = msg_t'($urandom_range(MSG_CRST, MSG_HSET));
    case (pick)
      MSG_HSET: begin
        put_text("H;SET");
        put_hex4();
      end
      MSG_HGET: put_text("H;GET;STATUS");
      MSG_HPING: begin
        put_text("H;PING");
        put_extra_fields();
      end
      MSG_HRST: put_text("H;RST");
      MSG_HUPD: begin
        put_text("H;UPD");
        put_hex4();
        put_hex4();
      end
      MSG_HTOG: begin
        put_text("H;TOG");
        put_hex4();
      end
      MSG_CACK: begin
        put_text("C;ACK;SET");
        put_hex4();
      end
      MSG_CERR: begin
        put_text("C;ERR;SET");
        put_decimal();
      end
      MSG_CSTATUS: begin
        put_text("C;STATUS");
        put_hex4();
        repeat (5) put_decimal();
      end
      MSG_CPONG: begin
        put_text("C;PONG");
        put_extra_fields();
      end
      default: put_text("C;RST");
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_host_lines();
    send_text("H;SET;00FF");
    send_text("H;SET;a5C3");
    send_text("H;GET;STATUS");
    send_text("H;PING");
    send_text("H;RST");
    send_text("H;UPD;FFFF;0000");
    send_text("H;TOG;1234");
  endtask

  task automatic test_client_lines();
    send_text("C;ACK;SET;BEEF");
    send_text("C;ERR;SET;-32768");
    send_text("C;ERR;SET;+7x");
    send_text("C;ERR;SET;99999");
    send_text("C;ERR;SET;--5");
    send_text("C;STATUS;ffff;0;65535;70000;12;-100");
    send_text("C;PONG");
    send_text("C;RST");
  endtask

  task automatic test_malformed_lines();
    send_text("h;PING");
    send_text("H;set;00FF");
    send_text("H;SET; 0FF");
    send_text("H;SET;0x1F");
    send_text("H;SET;12345");
    send_text("H;SET;+123");
    send_text("H;RST;");
    send_text("C;STATUS;1234;1;2;3;4");
    send_text("C;UPD;0000;0000");
    send_text("H");
    send_text(";");
    // more semicolons than the field bound, then text that is ignored
    send_text("H;PING;;;;;;;;;;;;tail");
    // zero byte and all-ones byte inside a field
    line_buf.delete();
    put_text("H;PING;");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    send_line();
  endtask

  task automatic test_random_lines(input int goal, input logic quiet);
    int        start;
    int        pick;
    int        pos;
    mutation_t how;
    calm  <= quiet;
    start = sent_bytes;
    while (sent_bytes - start < goal) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        // noise with a fair share of semicolons
        line_buf.delete();
        repeat ($urandom_range(24, 1))
          line_buf.push_back(($urandom_range(4) == 0) ? CH_SEMI : 8'($urandom_range(255)));
      end else begin
        build_wellformed();
        if (pick < 35) begin
          pos = $urandom_range(line_buf.size() - 1);
          how = mutation_t'($urandom_range(3));
          case (how)
            MUT_REPLACE: line_buf[pos] = 8'($urandom_range(255));
            MUT_SPLIT:   line_buf.insert(pos, CH_SEMI);
            MUT_DROP:    if (line_buf.size() > 1) line_buf.delete(pos);
            default:     line_buf[pos] = line_buf[pos] ^ 8'h20;
          endcase
        end
      end
      send_line();
      if ($urandom_range(19) == 0) wait_for_replies();
    end
    calm <= 1'b0;
  endtask

  // Back-to-back lines, then the sender holds until all replies are in
  task automatic test_drain_pause();
    repeat (6) begin
      build_wellformed();
      send_line();
    end
    wait_for_replies();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_line_byte = '0;
    in_line_end  = 1'b0;
    out_ready    = 1'b0;
    calm         = 1'b0;
    errors       = 0;
    sent_bytes   = 0;
    reset_line_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_host_lines();
    test_client_lines();
    test_malformed_lines();
    test_drain_pause();
    test_random_lines(250, 1'b0);
    test_random_lines(150, 1'b1);

    wait_for_replies();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("semicolon_command_line_parser verification clean");
    end else begin
      $display("semicolon_command_line_parser verification failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(4_000_000);
    $display("semicolon_command_line_parser verification failed");
    $finish;
  end

endmodule
